// ===== design/pstb_pkg.sv =====
// pstb_pkg: shared types and codes for the per-source token bucket limiter
// no dependencies
package pstb_pkg;

	localparam logic [1:0] ST_ACCEPTED     = 2'd0;
	localparam logic [1:0] ST_SOURCE_EMPTY = 2'd1;
	localparam logic [1:0] ST_GLOBAL_EMPTY = 2'd2;
	localparam logic [1:0] ST_TABLE_FULL   = 2'd3;

	localparam logic [1:0] REG_SOURCE_CAP = 2'd0;
	localparam logic [1:0] REG_GLOBAL_CAP = 2'd1;
	localparam logic [1:0] REG_NEW_TOKENS = 2'd2;
	localparam logic [1:0] REG_START_SECS = 2'd3;

	// controller to datapath
	typedef struct packed {
		logic load;      // capture input item, start search
		logic scan;      // examine one table entry
		logic decide;    // refill, charge and write back
	} pstb_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic scan_done;
	} pstb_sts_t;

endpackage

// ===== design/pstb_ctrl.sv =====
// pstb_ctrl: sequencer for search, decision and result hand-off
// depends on pstb_pkg
module pstb_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	output pstb_pkg::pstb_cmd_t cmd,
	input  pstb_pkg::pstb_sts_t sts
);

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_SCAN   = 4'b0010,
		S_DECIDE = 4'b0100,
		S_OUT    = 4'b1000
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE:   if (in_valid) state_q <= S_SCAN;
				S_SCAN:   if (sts.scan_done) state_q <= S_DECIDE;
				S_DECIDE: state_q <= S_OUT;
				S_OUT:    if (out_ready) state_q <= S_IDLE;
				default:  state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready   = (state_q == S_IDLE);
	assign out_valid  = (state_q == S_OUT);
	assign cmd.load   = (state_q == S_IDLE) && in_valid;
	assign cmd.scan   = (state_q == S_SCAN);
	assign cmd.decide = (state_q == S_DECIDE);

endmodule

// ===== design/pstb_dp.sv =====
// pstb_dp: source table memory, global bucket, counters and result registers
// depends on pstb_pkg
module pstb_dp #(
	parameter int ENTRIES    = 64,
	parameter int TOKEN_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  pstb_pkg::pstb_cmd_t cmd,
	output pstb_pkg::pstb_sts_t sts,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_sel,
	input  logic                cfg_hit,
	input  logic [31:0]         cfg_wdata,
	input  logic [31:0]         source_address,
	input  logic [31:0]         packet_tag,
	input  logic [31:0]         now_seconds,
	output logic [31:0]         packet_tag_out,
	output logic                accept,
	output logic [1:0]          status,
	output logic                new_source,
	output logic [15:0]         source_tokens_left,
	output logic [15:0]         global_tokens_left
);

	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CW = $clog2(ENTRIES + 1);
	localparam int TB = TOKEN_BITS;
	localparam logic [TB-1:0] TMAX = {TB{1'b1}};

	function automatic logic [TB-1:0] lim(input logic [15:0] v);
		logic [TB-1:0] r;
		if (TB >= 16) r = TB'(v);
		else if (v > 16'(TMAX)) r = TMAX;
		else r = v[TB-1:0];
		return r;
	endfunction

	// refilled count: tokens + (now - stamp) saturating at cap, tokens unchanged unless now is past stamp
	function automatic logic [TB-1:0] refill(input logic [TB-1:0] tok,
		input logic [31:0] stamp, input logic [31:0] now, input logic [TB-1:0] cap);
		logic [32:0] sum;
		logic [TB-1:0] r;
		sum = 33'(tok) + 33'(now - stamp);
		r = tok;
		if (now > stamp) r = (sum > 33'(cap)) ? cap : sum[TB-1:0];
		return r;
	endfunction

	logic [15:0] src_cap_q, glb_cap_q, new_tok_q;
	logic [TB-1:0] glb_tok_q;
	logic [31:0] glb_time_q;
	logic [31:0] packet_count_q, drop_count_q;
	logic [6:0] source_count_q;

	logic [ENTRIES-1:0] valid_q;
	logic [31:0]   mem_addr [ENTRIES];
	logic [TB-1:0] mem_tok  [ENTRIES];
	logic [31:0]   mem_time [ENTRIES];

	logic [31:0] addr_q, tag_q, now_q;
	logic [CW-1:0] idx_q;
	logic hit_q, free_found_q;
	logic [IW-1:0] hit_idx_q, free_idx_q;
	logic [TB-1:0] hit_tok_q;
	logic [31:0]   hit_time_q;
	logic [31:0]   rd_addr_q, rd_time_q;
	logic [TB-1:0] rd_tok_q;
	logic          rd_ok_q;
	logic [IW-1:0] rd_idx_q;

	logic [IW-1:0] idx;
	assign idx = idx_q[IW-1:0];
	assign sts.scan_done = cmd.scan && (hit_q || (idx_q == CW'(ENTRIES)));

	// registered memory read, one entry per cycle
	always_ff @(posedge clk) begin
		if (cmd.scan && idx_q < CW'(ENTRIES)) begin
			rd_addr_q <= mem_addr[idx];
			rd_tok_q  <= mem_tok[idx];
			rd_time_q <= mem_time[idx];
			rd_idx_q  <= idx;
		end
	end

	// search: read issued at idx, compared the next cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			hit_q <= 1'b0;
			free_found_q <= 1'b0;
			rd_ok_q <= 1'b0;
		end else if (cmd.load) begin
			idx_q <= '0;
			hit_q <= 1'b0;
			free_found_q <= 1'b0;
			rd_ok_q <= 1'b0;
		end else if (cmd.scan && !hit_q) begin
			rd_ok_q <= (idx_q < CW'(ENTRIES));
			if (idx_q < CW'(ENTRIES)) idx_q <= idx_q + 1'b1;
			if (rd_ok_q) begin
				if (valid_q[rd_idx_q] && rd_addr_q == addr_q) begin
					hit_q <= 1'b1;
					hit_idx_q <= rd_idx_q;
					// the read register moves on, so keep the matching bucket
					hit_tok_q <= rd_tok_q;
					hit_time_q <= rd_time_q;
				end else if (!valid_q[rd_idx_q] && !free_found_q) begin
					free_found_q <= 1'b1;
					free_idx_q <= rd_idx_q;
				end
			end
		end
	end

	// last pending compare folds in when index reaches the end
	logic last_hit, last_free;
	assign last_hit  = rd_ok_q && valid_q[rd_idx_q] && rd_addr_q == addr_q;
	assign last_free = rd_ok_q && !valid_q[rd_idx_q] && !free_found_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			addr_q <= source_address;
			tag_q  <= packet_tag;
			now_q  <= now_seconds;
		end
	end

	// hit state captured on the cycle that the scan finishes
	logic hit_f_q, free_f_q;
	logic [IW-1:0] sel_f_q;
	logic [TB-1:0] tok_f_q;
	logic [31:0]   time_f_q;
	always_ff @(posedge clk) begin
		if (sts.scan_done) begin
			if (hit_q) begin
				hit_f_q <= 1'b1; free_f_q <= 1'b0; sel_f_q <= hit_idx_q;
				tok_f_q <= hit_tok_q; time_f_q <= hit_time_q;
			end else if (last_hit) begin
				hit_f_q <= 1'b1; free_f_q <= 1'b0; sel_f_q <= rd_idx_q;
				tok_f_q <= rd_tok_q; time_f_q <= rd_time_q;
			end else begin
				hit_f_q <= 1'b0;
				free_f_q <= free_found_q || last_free;
				sel_f_q <= free_found_q ? free_idx_q : rd_idx_q;
				tok_f_q <= lim(new_tok_q); time_f_q <= now_q;
			end
		end
	end

	logic [TB-1:0] s_tok, g_tok;
	logic have;
	assign have  = hit_f_q || free_f_q;
	assign s_tok = refill(tok_f_q, time_f_q, now_q, lim(src_cap_q));
	assign g_tok = refill(glb_tok_q, glb_time_q, now_q, lim(glb_cap_q));

	logic [1:0] st;
	always_comb begin
		priority if (!have) st = pstb_pkg::ST_TABLE_FULL;
		else if (s_tok == '0) st = pstb_pkg::ST_SOURCE_EMPTY;
		else if (g_tok == '0) st = pstb_pkg::ST_GLOBAL_EMPTY;
		else st = pstb_pkg::ST_ACCEPTED;
	end
	logic ok;
	assign ok = (st == pstb_pkg::ST_ACCEPTED);
	logic [TB-1:0] s_new, g_new;
	assign s_new = ok ? s_tok - 1'b1 : s_tok;
	assign g_new = ok ? g_tok - 1'b1 : g_tok;

	always_ff @(posedge clk) begin
		if (cmd.decide && have) begin
			mem_addr[sel_f_q] <= addr_q;
			mem_tok[sel_f_q]  <= s_new;
			mem_time[sel_f_q] <= (now_q > time_f_q) ? now_q : time_f_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.decide) begin
			packet_tag_out     <= tag_q;
			accept             <= ok;
			status             <= st;
			new_source         <= free_f_q;
			source_tokens_left <= have ? 16'(s_new) : 16'd0;
			global_tokens_left <= 16'(g_new);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_cap_q <= 16'd10;
			glb_cap_q <= 16'd100;
			new_tok_q <= 16'd10;
			glb_tok_q <= lim(16'd100);
			glb_time_q <= '0;
			valid_q <= '0;
			packet_count_q <= '0;
			drop_count_q <= '0;
			source_count_q <= '0;
		end else if (cfg_we && cfg_hit) begin
			unique case (cfg_sel)
				pstb_pkg::REG_SOURCE_CAP: src_cap_q <= cfg_wdata[15:0];
				pstb_pkg::REG_GLOBAL_CAP: begin
					glb_cap_q <= cfg_wdata[15:0];
					glb_tok_q <= lim(cfg_wdata[15:0]);
				end
				pstb_pkg::REG_NEW_TOKENS: new_tok_q <= cfg_wdata[15:0];
				pstb_pkg::REG_START_SECS: glb_time_q <= cfg_wdata;
				default: ;
			endcase
		end else if (cmd.decide) begin
			glb_tok_q <= g_new;
			if (now_q > glb_time_q) glb_time_q <= now_q;
			if (free_f_q) begin
				valid_q[sel_f_q] <= 1'b1;
				source_count_q <= source_count_q + 7'd1;
			end
			packet_count_q <= packet_count_q + 32'd1;
			if (!ok) drop_count_q <= drop_count_q + 32'd1;
		end
	end

	// counters are internal status only
	logic unused_cnt;
	assign unused_cnt = ^{packet_count_q, drop_count_q, source_count_q};

endmodule

// ===== design/per_source_token_bucket_limiter.sv =====
// per_source_token_bucket_limiter: per-source and global token bucket policer
// the item is captured in idle, the table is searched one entry a cycle until a hit
// or the end, then the bucket is refilled and charged and the verdict held until taken
// one item at a time: the next item is accepted the cycle after the verdict leaves
// reset: table valid bits cleared at once, registers to 10, 100, 10, 0
module per_source_token_bucket_limiter #(
	parameter int ENTRIES    = 64,
	parameter int TOKEN_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] source_address,
	input  logic [31:0] packet_tag,
	input  logic [31:0] now_seconds,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] packet_tag_out,
	output logic        accept,
	output logic [1:0]  status,
	output logic        new_source,
	output logic [15:0] source_tokens_left,
	output logic [15:0] global_tokens_left
);

	pstb_pkg::pstb_cmd_t cmd;
	pstb_pkg::pstb_sts_t sts;

	// sequencer: idle, table search, decision, verdict hold
	pstb_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready),
		.cmd(cmd), .sts(sts)
	);

	// indexes beyond the register list are ignored
	pstb_dp #(.ENTRIES(ENTRIES), .TOKEN_BITS(TOKEN_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.cfg_we(cfg_we), .cfg_sel(cfg_index[1:0]), .cfg_hit(!cfg_index[2]),
		.cfg_wdata(cfg_wdata),
		.source_address(source_address), .packet_tag(packet_tag),
		.now_seconds(now_seconds),
		.packet_tag_out(packet_tag_out), .accept(accept), .status(status),
		.new_source(new_source), .source_tokens_left(source_tokens_left),
		.global_tokens_left(global_tokens_left)
	);

endmodule

// ===== design/pstb_checker.sv =====
// pstb_checker: port-level checks on the limiter's verdicts
// binds to per_source_token_bucket_limiter
module pstb_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic        accept,
	input logic [1:0]  status,
	input logic        new_source,
	input logic [15:0] source_tokens_left
);

	a_accept_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (accept == (status == pstb_pkg::ST_ACCEPTED))) else $error("accept");
	a_full_no_new: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == pstb_pkg::ST_TABLE_FULL |-> !new_source && source_tokens_left == 0)
		else $error("full");
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("overlap");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status)) else $error("hold");

endmodule

bind per_source_token_bucket_limiter pstb_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_ready(in_ready), .out_valid(out_valid),
	.out_ready(out_ready), .accept(accept), .status(status),
	.new_source(new_source), .source_tokens_left(source_tokens_left)
);

// ===== dv/per_source_token_bucket_limiter_tb.sv =====
// per_source_token_bucket_limiter_tb: self-checking bench for the token bucket limiter
// holds its own bucket predictor and verdict scoreboard; depends on pstb_pkg and the rtl
`timescale 1ns / 1ps

module per_source_token_bucket_limiter_tb;

	localparam int ENTRIES = 64;
	localparam int LAT = ENTRIES + 8;

	typedef struct packed {
		logic [31:0] tag;
		logic        acc;
		logic [1:0]  st;
		logic        created;
		logic [15:0] src_left;
		logic [15:0] glb_left;
	} verdict_t;

	// bucket predictor plus queue of expected verdicts
	class verdict_board;
		logic [15:0] src_cap, glb_cap, new_tokens;
		logic [31:0] start_secs;
		bit          used[ENTRIES];
		logic [31:0] addr[ENTRIES];
		logic [15:0] tokens[ENTRIES];
		logic [31:0] stamp[ENTRIES];
		logic [15:0] glb_tokens;
		logic [31:0] glb_stamp;
		verdict_t    pending[$];
		int          errors;
		int          checked;
		int          accepted_cnt;
		int          full_cnt;

		function new();
			src_cap = 10; glb_cap = 100; new_tokens = 10; start_secs = 0;
			foreach (used[i]) used[i] = 0;
			glb_tokens = 100; glb_stamp = 0;
			errors = 0; checked = 0; accepted_cnt = 0; full_cnt = 0;
		endfunction

		function void write_reg(logic [2:0] idx, logic [31:0] val);
			case (idx)
				3'(pstb_pkg::REG_SOURCE_CAP): src_cap = val[15:0];
				3'(pstb_pkg::REG_GLOBAL_CAP): begin
					glb_cap = val[15:0];
					glb_tokens = val[15:0];
				end
				3'(pstb_pkg::REG_NEW_TOKENS): new_tokens = val[15:0];
				3'(pstb_pkg::REG_START_SECS): begin
					start_secs = val;
					glb_stamp = val;
				end
				default: ;
			endcase
		endfunction

		// saturating refill, only when time moves forward
		function automatic void top_up(ref logic [15:0] tk, ref logic [31:0] ts,
				input logic [31:0] now, input logic [15:0] cap);
			logic [47:0] sum;
			if (now > ts) begin
				sum = 48'(tk) + 48'(now - ts);
				tk = (sum > 48'(cap)) ? cap : sum[15:0];
				ts = now;
			end
		endfunction

		function void note_packet(logic [31:0] a, logic [31:0] tag, logic [31:0] now);
			int hit, free_slot;
			verdict_t v;
			hit = -1; free_slot = -1;
			v = '0;
			v.tag = tag;
			for (int i = 0; i < ENTRIES; i++) begin
				if (used[i]) begin
					if (hit < 0 && addr[i] == a) hit = i;
				end else if (free_slot < 0) free_slot = i;
			end
			if (hit < 0 && free_slot >= 0) begin
				hit = free_slot;
				used[hit] = 1; addr[hit] = a;
				tokens[hit] = new_tokens; stamp[hit] = now;
				v.created = 1;
			end
			if (hit >= 0) top_up(tokens[hit], stamp[hit], now, src_cap);
			top_up(glb_tokens, glb_stamp, now, glb_cap);
			if (hit < 0) begin
				v.st = pstb_pkg::ST_TABLE_FULL;
				full_cnt++;
			end else if (tokens[hit] == 0) v.st = pstb_pkg::ST_SOURCE_EMPTY;
			else if (glb_tokens == 0) v.st = pstb_pkg::ST_GLOBAL_EMPTY;
			else begin
				tokens[hit]--; glb_tokens--;
				v.acc = 1; v.st = pstb_pkg::ST_ACCEPTED;
				accepted_cnt++;
			end
			if (hit >= 0) v.src_left = tokens[hit];
			v.glb_left = glb_tokens;
			pending.push_back(v);
		endfunction

		function void check_verdict(verdict_t got);
			verdict_t e;
			checked++;
			if (pending.size() == 0) begin
				$error("verdict with nothing expected: tag %h", got.tag);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (got.tag !== e.tag) begin
				$error("packet_tag_out exp %h got %h", e.tag, got.tag); errors++;
			end
			if (got.acc !== e.acc) begin
				$error("accept exp %0d got %0d", e.acc, got.acc); errors++;
			end
			if (got.st !== e.st) begin
				$error("status exp %0d got %0d", e.st, got.st); errors++;
			end
			if (got.created !== e.created) begin
				$error("new_source exp %0d got %0d", e.created, got.created); errors++;
			end
			if (got.src_left !== e.src_left) begin
				$error("source_tokens_left exp %0d got %0d", e.src_left, got.src_left);
				errors++;
			end
			if (got.glb_left !== e.glb_left) begin
				$error("global_tokens_left exp %0d got %0d", e.glb_left, got.glb_left);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 0;
	logic        arst_n = 0;
	logic        cfg_we = 0;
	logic [2:0]  cfg_index = '0;
	logic [31:0] cfg_wdata = '0;
	logic        in_valid = 0;
	logic        in_ready;
	logic [31:0] source_address = '0;
	logic [31:0] packet_tag = '0;
	logic [31:0] now_seconds = '0;
	logic        out_valid;
	logic        out_ready = 0;
	logic [31:0] packet_tag_out;
	logic        accept;
	logic [1:0]  status;
	logic        new_source;
	logic [15:0] source_tokens_left;
	logic [15:0] global_tokens_left;

	verdict_board board = new();
	logic [31:0]  clock_secs;      // stimulus time
	logic [31:0]  addr_pool[16];   // recurring sources so buckets drain and refill
	int           sent = 0;

	always #4 clk = ~clk;

	per_source_token_bucket_limiter #(.ENTRIES(ENTRIES), .TOKEN_BITS(16)) u_top (.*);

	// mostly short gaps, now and then a long one
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// output side: random stall, checks on accepting edges
	initial begin
		int g;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			g = gap_len();
			out_ready = (g == 0) || ($urandom_range(0, 3) == 0);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			board.check_verdict({packet_tag_out, accept, status, new_source,
				source_tokens_left, global_tokens_left});
	end

	// input items are noted in the predictor at the accepting edge
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) begin
			board.note_packet(source_address, packet_tag, now_seconds);
			sent++;
		end
	end

	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		@(negedge clk);
		cfg_we = 1; cfg_index = idx; cfg_wdata = val;
		board.write_reg(idx, val);
		@(negedge clk);
		cfg_we = 0;
	endtask

	// send one packet; returns at the falling edge after acceptance
	task automatic send_packet(logic [31:0] a, logic [31:0] tag, logic [31:0] now);
		int g;
		g = gap_len();
		repeat (g) @(negedge clk);
		in_valid = 1; source_address = a; packet_tag = tag; now_seconds = now;
		do @(posedge clk); while (!(in_valid && in_ready));
		@(negedge clk);
		in_valid = 0;
	endtask

	// wait until all verdicts are back plus the worst-case latency
	task automatic drain();
		while (board.pending.size() != 0) @(negedge clk);
		repeat (LAT) @(negedge clk);
	endtask

	task automatic random_phase(int n, int pool_sz);
		logic [31:0] a;
		for (int k = 0; k < n; k++) begin
			case ($urandom_range(0, 9))
				0: clock_secs = clock_secs + $urandom_range(50, 70000);
				1, 2: clock_secs = clock_secs + 1;
				default: ;
			endcase
			if ($urandom_range(0, 9) < 8) a = addr_pool[$urandom_range(0, pool_sz - 1)];
			else a = $urandom();
			send_packet(a, $urandom(), clock_secs);
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		foreach (addr_pool[i]) addr_pool[i] = $urandom();
		addr_pool[0] = 32'h0000_0000;
		addr_pool[1] = 32'hFFFF_FFFF;

		// directed: reset settings, field extremes, time standing still and drained
		clock_secs = 0;
		send_packet(32'h0, 32'h0, 0);
		send_packet(32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
		for (int k = 0; k < 11; k++) send_packet(32'h0, k, 0);  // source runs empty
		send_packet(32'h0, 32'hA5A5_5A5A, 3);                    // refill by 3
		send_packet(32'h0, 32'h5A5A_A5A5, 32'hFFFF_FFFF);        // big jump saturates
		clock_secs = 32'hFFFF_FFFF;
		drain();

		// tiny global cap: one accept drains it, then both empty, new source given zero tokens
		write_reg(3'(pstb_pkg::REG_START_SECS), 32'hFFFF_FFFF);
		write_reg(3'(pstb_pkg::REG_GLOBAL_CAP), 1);
		write_reg(3'(pstb_pkg::REG_NEW_TOKENS), 0);
		write_reg(3'(pstb_pkg::REG_SOURCE_CAP), 1);
		write_reg(3'd5, 32'h1234_5678);  // unused index does nothing
		send_packet(32'hFFFF_FFFF, 1, clock_secs);
		send_packet(32'hFFFF_FFFF, 2, clock_secs);
		send_packet(32'h1111_1111, 3, clock_secs);
		drain();

		// fill the table to see table full
		write_reg(3'(pstb_pkg::REG_START_SECS), 0);
		write_reg(3'(pstb_pkg::REG_GLOBAL_CAP), 16'hFFFF);
		write_reg(3'(pstb_pkg::REG_SOURCE_CAP), 16'hFFFF);
		write_reg(3'(pstb_pkg::REG_NEW_TOKENS), 16'hFFFF);
		clock_secs = 0;
		for (int k = 0; k < ENTRIES + 2; k++)
			send_packet(32'hC0A8_0000 + k, 32'h100 + k, clock_secs);
		drain();

		// random phases under varied settings; the table stays full after the fill
		random_phase(200, 16);
		drain();
		write_reg(3'(pstb_pkg::REG_SOURCE_CAP), $urandom_range(1, 8));
		write_reg(3'(pstb_pkg::REG_GLOBAL_CAP), $urandom_range(1, 20));
		write_reg(3'(pstb_pkg::REG_NEW_TOKENS), $urandom_range(0, 5));
		write_reg(3'(pstb_pkg::REG_START_SECS), clock_secs);
		random_phase(200, 16);
		drain();
		write_reg(3'(pstb_pkg::REG_SOURCE_CAP), $urandom_range(1, 65535));
		write_reg(3'(pstb_pkg::REG_GLOBAL_CAP), $urandom_range(1, 65535));
		write_reg(3'(pstb_pkg::REG_NEW_TOKENS), $urandom_range(0, 65535));
		write_reg(3'(pstb_pkg::REG_START_SECS), $urandom());
		random_phase(200, 16);
		drain();
		write_reg(3'(pstb_pkg::REG_START_SECS), 32'hFFFF_FFF0);
		write_reg(3'(pstb_pkg::REG_GLOBAL_CAP), 3);
		random_phase(170, 16);
		drain();

		$display("covered %0d packets, %0d verdicts: %0d accepted, %0d table full",
			sent, board.checked, board.accepted_cnt, board.full_cnt);
		if (board.errors == 0 && board.pending.size() == 0)
			$display("per_source_token_bucket_limiter_tb: done, clean");
		else
			$display("per_source_token_bucket_limiter_tb: done, errors");
		$finish;
	end

	// worst run: ~850 items x (long gaps + stall + table search) is well under this
	initial begin
		#20ms;
		$display("per_source_token_bucket_limiter_tb: done, errors");
		$finish;
	end

endmodule
